>>> src/ucr_pkg.sv
// Package with the commands, the word group type and the lead byte decode of the reassembler.
package ucr_pkg;

	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_FLUSH   = 2'd1;
	localparam logic [1:0] CMD_DISCARD = 2'd2;

	localparam int CARRY_DEPTH = 3;
	localparam int GRP_MAX     = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] MASK_1 = 8'h80;
	localparam logic [7:0] MASK_2 = 8'hE0;
	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] MASK_3 = 8'hF0;
	localparam logic [7:0] MASK_4 = 8'hF8;
	localparam logic [7:0] MASK_C = 8'hC0;
	localparam logic [7:0] CONT   = 8'h80;

	typedef struct packed {
		logic [GRP_MAX-1:0][7:0] bytes;
		logic [GRP_MAX-1:0]      ends;
		logic [2:0]              num;
		logic                    flush;
	} ucr_grp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ucr_fifo_st_t;

	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] len;
		len = 3'd0;
		if ((c & MASK_1) == 8'h00) begin
			len = 3'd1;
		end else if ((c & MASK_2) == LEAD_2) begin
			len = 3'd2;
		end else if ((c & MASK_3) == MASK_2) begin
			len = 3'd3;
		end else if ((c & MASK_4) == MASK_3) begin
			len = 3'd4;
		end
		return len;
	endfunction

endpackage

>>> src/ucr_if.sv
// Stream interfaces for the command channel and the byte channel.
interface ucr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface ucr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       char_end;
	logic       from_flush;
	logic       last;

	modport source (output valid, output out_byte, output char_end, output from_flush,
		output last, input ready);
	modport sink (input valid, input out_byte, input char_end, input from_flush,
		input last, output ready);
endinterface

>>> src/ucr_front.sv
// Front end: accepts commands, scans the carry run and builds groups of finished bytes.
module ucr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	ucr_in_if.sink                in_ch,
	input  ucr_pkg::ucr_fifo_st_t fifo_st,
	output logic                  push,
	output ucr_pkg::ucr_grp_t     grp
);
	import ucr_pkg::*;

	logic [7:0] carry_q [CARRY_DEPTH];
	logic [1:0] carry_cnt_q;
	logic [7:0] run [GRP_MAX];
	logic [7:0] nc [CARRY_DEPTH];
	logic [2:0] rem;
	logic [GRP_MAX-1:0] emit;
	logic [GRP_MAX-1:0] endm;
	logic [GRP_MAX-1:0][7:0] pb;
	logic [GRP_MAX-1:0] pe;
	logic [2:0] pk;
	logic accept;

	assign in_ch.ready = !fifo_st.full;
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin : scan
		logic [2:0] n;
		logic [2:0] pos;
		logic [2:0] len;
		logic [2:0] idx;
		logic       stop;
		logic       ok;
		n = {1'b0, carry_cnt_q} + 3'd1;
		len = 3'd0;
		idx = 3'd0;
		ok = 1'b0;
		for (int j = 0; j < GRP_MAX; j++) begin
			if (3'(j) < {1'b0, carry_cnt_q}) begin
				run[j] = carry_q[j[1:0]];
			end else if (3'(j) == {1'b0, carry_cnt_q}) begin
				run[j] = in_ch.data_byte;
			end else begin
				run[j] = 8'h00;
			end
		end
		pos = 3'd0;
		stop = 1'b0;
		emit = '0;
		endm = '0;
		for (int s = 0; s < GRP_MAX; s++) begin
			if (!stop && pos < n) begin
				len = lead_len(run[pos[1:0]]);
				if (len == 3'd0) begin
					pos = pos + 3'd1;
				end else if (pos + len > n) begin
					stop = 1'b1;
				end else begin
					ok = 1'b1;
					for (int j = 1; j < GRP_MAX; j++) begin
						idx = pos + 3'(j);
						if (3'(j) < len && (run[idx[1:0]] & MASK_C) != CONT) begin
							ok = 1'b0;
						end
					end
					if (ok) begin
						for (int q = 0; q < GRP_MAX; q++) begin
							if (3'(q) >= pos && 3'(q) < pos + len) begin
								emit[q] = 1'b1;
							end
							if (3'(q) == pos + len - 3'd1) begin
								endm[q] = 1'b1;
							end
						end
						pos = pos + len;
					end else begin
						pos = pos + 3'd1;
					end
				end
			end
		end
		rem = n - pos;
		for (int j = 0; j < CARRY_DEPTH; j++) begin
			idx = pos + 3'(j);
			nc[j] = run[idx[1:0]];
		end
	end

	always_comb begin
		pk = 3'd0;
		pb = '0;
		pe = '0;
		for (int q = 0; q < GRP_MAX; q++) begin
			if (emit[q]) begin
				pb[pk[1:0]] = run[q];
				pe[pk[1:0]] = endm[q];
				pk = pk + 3'd1;
			end
		end
	end

	always_comb begin
		grp = '0;
		case (in_ch.command)
			CMD_PUSH: begin
				grp.bytes = pb;
				grp.ends = pe;
				grp.num = pk;
			end
			CMD_FLUSH: begin
				for (int j = 0; j < CARRY_DEPTH; j++) begin
					grp.bytes[j] = carry_q[j];
					grp.ends[j] = (3'(j) == {1'b0, carry_cnt_q} - 3'd1);
				end
				grp.num = {1'b0, carry_cnt_q};
				grp.flush = 1'b1;
			end
			default: begin
				grp.num = 3'd0;
			end
		endcase
	end

	assign push = accept && (grp.num != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_cnt_q <= 2'd0;
		end else if (accept) begin
			case (in_ch.command)
				CMD_PUSH: begin
					carry_cnt_q <= rem[1:0];
				end
				CMD_FLUSH, CMD_DISCARD: begin
					carry_cnt_q <= 2'd0;
				end
				default: begin
					carry_cnt_q <= carry_cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_ch.command == CMD_PUSH) begin
			carry_q <= nc;
		end
	end

	a_carry_lead: assert property (@(posedge clk) disable iff (!arst_n)
		carry_cnt_q != 2'd0 |-> lead_len(carry_q[0]) != 3'd0)
		else $error("carry store does not start with a lead byte");

endmodule

>>> src/ucr_fifo.sv
// Short queue of byte groups between the front end and the back end.
module ucr_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ucr_pkg::ucr_grp_t     wr_grp,
	input  logic                  pop,
	output ucr_pkg::ucr_grp_t     head,
	output ucr_pkg::ucr_fifo_st_t st
);
	import ucr_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	ucr_grp_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     cnt_q;

	assign st.full = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign st.empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_grp;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !st.full)
		else $error("group written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !st.empty)
		else $error("group taken from an empty queue");

endmodule

>>> src/ucr_back.sv
// Back end: sends the bytes of each queued group one word at a time through an output register.
module ucr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ucr_pkg::ucr_grp_t     head,
	input  ucr_pkg::ucr_fifo_st_t fifo_st,
	output logic                  pop,
	ucr_out_if.source             out_ch
);
	import ucr_pkg::*;

	logic [1:0] idx_q;
	logic       o_valid_q;
	logic [7:0] o_byte_q;
	logic       o_end_q;
	logic       o_flush_q;
	logic       o_last_q;
	logic       load;
	logic       is_last;

	assign load = !o_valid_q || out_ch.ready;
	assign is_last = ({1'b0, idx_q} == head.num - 3'd1);
	assign pop = load && !fifo_st.empty && is_last;

	assign out_ch.valid = o_valid_q;
	assign out_ch.out_byte = o_byte_q;
	assign out_ch.char_end = o_end_q;
	assign out_ch.from_flush = o_flush_q;
	assign out_ch.last = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			o_valid_q <= !fifo_st.empty;
			if (!fifo_st.empty) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !fifo_st.empty) begin
			o_byte_q <= head.bytes[idx_q];
			o_end_q <= head.ends[idx_q];
			o_flush_q <= head.flush;
			o_last_q <= is_last;
		end
	end

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_st.empty |-> ({1'b0, idx_q} < head.num))
		else $error("byte index beyond the head group");

endmodule

>>> src/utf8_char_reassembler.sv
// Top level of the UTF-8 character reassembler.
//
// Channel  Modport  Words
// in_ch    sink     command and data_byte, one per accepted word
// out_ch   source   out_byte, char_end, from_flush and last, zero to four per command
//
// One command is accepted per cycle while the four-entry group queue has room.
// The back end sends one byte per cycle while a group is queued and out_ch.ready is high, from its output register;
// the group queue lets the front keep taking commands.
// Reset clears the carry count, the queue pointers and the output valid.
// A stall on out_ch fills the queue and then holds in_ch.ready low.
module utf8_char_reassembler (
	input  logic       clk,
	input  logic       arst_n,
	ucr_in_if.sink     in_ch,
	ucr_out_if.source  out_ch
);
	import ucr_pkg::*;

	ucr_grp_t     wr_grp;
	ucr_grp_t     head;
	ucr_fifo_st_t fifo_st;
	logic         push;
	logic         pop;

	ucr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.fifo_st (fifo_st),
		.push    (push),
		.grp     (wr_grp)
	);

	ucr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_grp (wr_grp),
		.pop    (pop),
		.head   (head),
		.st     (fifo_st)
	);

	ucr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.fifo_st (fifo_st),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the UTF-8 character reassembler with directed and random byte streams.
module tb;
	import ucr_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 95;
	localparam int CALM_TAIL    = 25;
	localparam int MAX_REPORTS  = 100;

	typedef struct {
		logic [1:0] command;
		logic [7:0] data_byte;
		bit         drain;
	} in_word_t;

	typedef struct {
		logic [7:0] out_byte;
		logic       char_end;
		logic       from_flush;
		logic       last;
	} out_word_t;

	logic clk;
	logic arst_n;

	ucr_in_if  in_if ();
	ucr_out_if out_if ();

	utf8_char_reassembler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	in_word_t  stim_q [$];
	out_word_t due_bytes [$];
	logic [7:0] carry [CARRY_DEPTH];
	int carry_n;
	int errors;
	int n_words;
	int n_bytes;
	int n_flush_runs;
	bit calm;
	int in_gap;
	int in_span;
	int in_chance;
	int out_gap;
	int out_span;
	int out_chance;

	task automatic report(input string what);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("%0t error: %s", $time, what);
		end
	endtask

	function automatic int utf8_span(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	function automatic int burst_gap(input int chance);
		if (chance != 0 && $urandom_range(0, 7) < chance) begin
			return $urandom_range(1, 14);
		end
		return 0;
	endfunction

	task automatic reassemble_word(input logic [1:0] cmd, input logic [7:0] b);
		logic [7:0] run [CARRY_DEPTH+1];
		out_word_t burst [$];
		int n;
		int i;
		int j;
		int span;
		bit good;
		bit stop;
		n = 0;
		i = 0;
		stop = 1'b0;
		if (cmd == CMD_PUSH) begin
			for (j = 0; j < carry_n; j++) begin
				run[n] = carry[j];
				n++;
			end
			run[n] = b;
			n++;
			while (i < n && !stop) begin
				span = utf8_span(run[i]);
				if (span == 0) begin
					i++;
				end else if (i + span > n) begin
					stop = 1'b1;
				end else begin
					good = 1'b1;
					for (j = 1; j < span; j++) begin
						if ((run[i+j] & MASK_C) != CONT) good = 1'b0;
					end
					if (good) begin
						for (j = 0; j < span; j++) begin
							burst.push_back('{run[i+j], j == span - 1, 1'b0, 1'b0});
						end
						i += span;
					end else begin
						i++;
					end
				end
			end
			carry_n = n - i;
			for (j = 0; j < carry_n; j++) begin
				carry[j] = run[i+j];
			end
		end else if (cmd == CMD_FLUSH) begin
			for (j = 0; j < carry_n; j++) begin
				burst.push_back('{carry[j], j == carry_n - 1, 1'b1, 1'b0});
			end
			if (carry_n > 0) n_flush_runs++;
			carry_n = 0;
		end else if (cmd == CMD_DISCARD) begin
			carry_n = 0;
		end
		if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
		foreach (burst[k]) due_bytes.push_back(burst[k]);
	endtask

	task automatic queue_word(input logic [1:0] cmd, input logic [7:0] b);
		stim_q.push_back('{cmd, b, 1'b0});
	endtask

	// Queues the first keep bytes of a character of the given span; bad_at marks a broken
	// continuation byte, or none when it is out of range.
	task automatic queue_char(input int span, input int keep, input int bad_at);
		logic [7:0] b;
		int j;
		for (j = 0; j < keep; j++) begin
			b = 8'($urandom);
			if (j == 0) begin
				case (span)
					1: b[7] = 1'b0;
					2: b[7:5] = 3'b110;
					3: b[7:4] = 4'b1110;
					default: b[7:3] = 5'b11110;
				endcase
			end else if (j == bad_at) begin
				if (b[7:6] == 2'b10) b[6] = 1'b1;
			end else begin
				b[7:6] = 2'b10;
			end
			queue_word(CMD_PUSH, b);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.command = CMD_PUSH;
		in_if.data_byte = 8'h00;
		out_if.ready = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("utf8_char_reassembler regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		in_word_t nxt;
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				reassemble_word(in_if.command, in_if.data_byte);
				n_words++;
			end
			calm = stim_q.size() < CALM_TAIL;
			if (in_span == 0) begin
				in_span = $urandom_range(20, 60);
				in_chance = $urandom_range(0, 3);
			end
			in_span--;
			if (!in_if.valid || in_if.ready) begin
				if (in_gap == 0 && !calm) in_gap = burst_gap(in_chance);
				if (in_gap > 0 && !calm) begin
					in_gap--;
					in_if.valid <= 1'b0;
				end else if (stim_q.size() == 0 || (stim_q[0].drain && due_bytes.size() != 0)) begin
					in_if.valid <= 1'b0;
				end else begin
					nxt = stim_q.pop_front();
					in_if.valid <= 1'b1;
					in_if.command <= nxt.command;
					in_if.data_byte <= nxt.data_byte;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				n_bytes++;
				if (due_bytes.size() == 0) begin
					report($sformatf("byte %02h arrived with nothing expected", out_if.out_byte));
				end else begin
					want = due_bytes.pop_front();
					if (out_if.out_byte !== want.out_byte)
						report($sformatf("out_byte %02h, expected %02h", out_if.out_byte,
							want.out_byte));
					if (out_if.char_end !== want.char_end)
						report($sformatf("char_end %b on byte %02h, expected %b", out_if.char_end,
							want.out_byte, want.char_end));
					if (out_if.from_flush !== want.from_flush)
						report($sformatf("from_flush %b on byte %02h, expected %b",
							out_if.from_flush, want.out_byte, want.from_flush));
					if (out_if.last !== want.last)
						report($sformatf("last %b on byte %02h, expected %b", out_if.last,
							want.out_byte, want.last));
				end
			end
			if (out_span == 0) begin
				out_span = $urandom_range(20, 60);
				out_chance = $urandom_range(0, 3);
			end
			out_span--;
			if (out_gap == 0 && !calm) out_gap = burst_gap(out_chance);
			if (out_gap > 0 && !calm) begin
				out_gap--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int target;
		int pick;
		int span;
		int k;
		queue_word(CMD_PUSH, 8'h00);
		queue_word(CMD_PUSH, 8'h7F);
		queue_word(CMD_PUSH, 8'hC3);
		queue_word(CMD_PUSH, 8'hA9);
		queue_word(CMD_PUSH, 8'hE2);
		queue_word(CMD_PUSH, 8'h82);
		queue_word(CMD_PUSH, 8'hAC);
		queue_word(CMD_PUSH, 8'hF0);
		queue_word(CMD_PUSH, 8'h9F);
		queue_word(CMD_PUSH, 8'h98);
		queue_word(CMD_PUSH, 8'h80);
		queue_word(CMD_PUSH, 8'h80);
		queue_word(CMD_PUSH, 8'hFF);
		queue_word(CMD_PUSH, 8'hF8);
		queue_word(CMD_PUSH, 8'hC3);
		queue_word(CMD_PUSH, 8'h41);
		queue_word(CMD_PUSH, 8'hE2);
		queue_word(CMD_SPARE, 8'hFF);
		queue_word(CMD_PUSH, 8'h82);
		queue_word(CMD_PUSH, 8'h41);
		queue_word(CMD_PUSH, 8'hF0);
		queue_word(CMD_PUSH, 8'h9F);
		queue_word(CMD_FLUSH, 8'hAA);
		queue_word(CMD_FLUSH, 8'h55);
		queue_word(CMD_PUSH, 8'hE2);
		queue_word(CMD_DISCARD, 8'hFF);
		queue_word(CMD_PUSH, 8'h41);

		target = stim_q.size() + RANDOM_WORDS;
		while (stim_q.size() < target) begin
			pick = $urandom_range(0, 99);
			span = $urandom_range(1, 4);
			if (pick < 65) begin
				queue_char(span, span, -1);
			end else if (pick < 73) begin
				span = $urandom_range(2, 4);
				queue_char(span, $urandom_range(1, span - 1), -1);
			end else if (pick < 81) begin
				span = $urandom_range(2, 4);
				queue_char(span, span, $urandom_range(1, span - 1));
			end else if (pick < 88) begin
				queue_word(CMD_PUSH, 8'($urandom));
			end else if (pick < 93) begin
				queue_word(CMD_FLUSH, 8'($urandom));
			end else if (pick < 97) begin
				queue_word(CMD_DISCARD, 8'($urandom));
			end else begin
				queue_word(CMD_SPARE, 8'($urandom));
			end
		end
		stim_q[27].drain = 1'b1;
		stim_q[stim_q.size() - 60].drain = 1'b1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_if.valid) @(posedge clk);
		for (k = 0; k < 2000 && due_bytes.size() != 0; k++) @(posedge clk);
		if (due_bytes.size() != 0) begin
			report($sformatf("%0d expected bytes never arrived", due_bytes.size()));
		end
		repeat (20) @(posedge clk);
		$display("Sent %0d words and checked %0d output bytes, %0d non-empty flushed runs.",
			n_words, n_bytes, n_flush_runs);
		if (errors == 0) begin
			$display("utf8_char_reassembler regression: pass");
		end else begin
			$display("utf8_char_reassembler regression: fail");
		end
		$finish;
	end

endmodule
